// ===== rtl/ttb_pkg.sv =====
// ---------------------------------------------------------------------------
// ttb_pkg
// Shared types and constants for the triangle tangent/binormal unit.
// ---------------------------------------------------------------------------
package ttb_pkg;

    localparam int COORD_W = 32;
    localparam int DELTA_W = 33;
    localparam int PROD_W  = 66;
    localparam int ACC_W   = 68;
    localparam int NORM_W  = 24;
    localparam int OUT_W   = 16;
    localparam int UNIT_Q14 = 16384;

    // A completed face handed from the front end to the back end.
    typedef struct packed {
        logic signed [DELTA_W-1:0] e1x, e1y, e1z;
        logic signed [DELTA_W-1:0] e2x, e2y, e2z;
        logic signed [DELTA_W-1:0] du1, dv1, du2, dv2;
    } face_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] tx, ty, tz;
        logic signed [OUT_W-1:0] bx, by, bz;
        logic                    degenerate;
    } result_t;

endpackage

// ===== rtl/ttb_front.sv =====
// ---------------------------------------------------------------------------
// ttb_front
// Collects corners, forms edge and uv deltas on the third corner.
// ---------------------------------------------------------------------------
module ttb_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [31:0]          px, py, pz, tu, tv,
    input  logic                 restart,
    output logic                 face_valid,
    input  logic                 face_ready,
    output ttb_pkg::face_t       face
);
    logic [31:0] c0_reg [5];
    logic [31:0] c1_reg [5];
    logic [1:0]  count_reg, count_next, cnt_eff;
    logic        fv_reg;
    ttb_pkg::face_t face_reg, face_next;

    function automatic logic signed [32:0] dl(input logic [31:0] a, input logic [31:0] b);
        dl = {a[31], a} - {b[31], b};
    endfunction

    assign in_ready   = !fv_reg || face_ready;
    assign face_valid = fv_reg;
    assign face       = face_reg;
    assign cnt_eff    = restart ? 2'd0 : count_reg;

    always_comb begin
        face_next     = face_reg;
        count_next    = count_reg;
        if (in_valid && in_ready) begin
            if (cnt_eff == 2'd2) begin
                count_next    = 2'd0;
                face_next.e1x = dl(c1_reg[0], c0_reg[0]);
                face_next.e1y = dl(c1_reg[1], c0_reg[1]);
                face_next.e1z = dl(c1_reg[2], c0_reg[2]);
                face_next.e2x = dl(px, c0_reg[0]);
                face_next.e2y = dl(py, c0_reg[1]);
                face_next.e2z = dl(pz, c0_reg[2]);
                face_next.du1 = dl(c1_reg[3], c0_reg[3]);
                face_next.dv1 = dl(c1_reg[4], c0_reg[4]);
                face_next.du2 = dl(tu, c0_reg[3]);
                face_next.dv2 = dl(tv, c0_reg[4]);
            end else begin
                count_next = cnt_eff + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        face_reg <= face_next;
        if (in_valid && in_ready && cnt_eff == 2'd0) begin
            c0_reg[0] <= px; c0_reg[1] <= py; c0_reg[2] <= pz;
            c0_reg[3] <= tu; c0_reg[4] <= tv;
        end
        if (in_valid && in_ready && cnt_eff == 2'd1) begin
            c1_reg[0] <= px; c1_reg[1] <= py; c1_reg[2] <= pz;
            c1_reg[3] <= tu; c1_reg[4] <= tv;
        end
        if (!aresetn) begin
            count_reg <= 2'd0;
            fv_reg    <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (in_valid && in_ready && cnt_eff == 2'd2) fv_reg <= 1'b1;
            else if (face_ready) fv_reg <= 1'b0;
        end
    end
endmodule

// ===== rtl/ttb_back.sv =====
// ---------------------------------------------------------------------------
// ttb_back
// Sequenced datapath: products, determinant, normalise via shared sqrt/div.
// ---------------------------------------------------------------------------
module ttb_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 face_valid,
    output logic                 face_ready,
    input  ttb_pkg::face_t       face,
    output logic                 res_valid,
    input  logic                 res_ready,
    output ttb_pkg::result_t     res
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_SUM  = 8'b0000_0100,
        S_MAG  = 8'b0000_1000,
        S_SQ   = 8'b0001_0000,
        S_SQRT = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    ttb_pkg::face_t f_reg;
    logic [3:0]  step_reg;          // product index
    logic        vec_reg;           // 0 = tangent, 1 = binormal
    logic [1:0]  comp_reg;
    logic signed [65:0] prod_reg [14];
    logic signed [67:0] det_reg;
    logic signed [67:0] v_reg [6];
    logic [67:0] mag_reg [3];
    logic        neg_reg [3];
    logic [23:0] c_reg [3];
    logic [49:0] s_reg;
    logic [49:0] rem_reg;
    logic [24:0] root_reg;
    logic [39:0] num_reg;
    logic [24:0] q_reg;
    logic [5:0]  it_reg;
    logic        bad_reg, flip_reg;
    logic signed [15:0] out_reg [6];
    logic signed [15:0] res_out_reg [6];
    logic        res_deg_reg;
    logic        rv_reg;

    // Operand pairs for the 14 products, one per cycle.
    logic signed [32:0] ma, mb;
    always_comb begin
        case (step_reg)
            4'd0:  begin ma = f_reg.du1; mb = f_reg.dv2; end
            4'd1:  begin ma = f_reg.du2; mb = f_reg.dv1; end
            4'd2:  begin ma = f_reg.dv2; mb = f_reg.e1x; end
            4'd3:  begin ma = f_reg.dv1; mb = f_reg.e2x; end
            4'd4:  begin ma = f_reg.dv2; mb = f_reg.e1y; end
            4'd5:  begin ma = f_reg.dv1; mb = f_reg.e2y; end
            4'd6:  begin ma = f_reg.dv2; mb = f_reg.e1z; end
            4'd7:  begin ma = f_reg.dv1; mb = f_reg.e2z; end
            4'd8:  begin ma = f_reg.du1; mb = f_reg.e2x; end
            4'd9:  begin ma = f_reg.du2; mb = f_reg.e1x; end
            4'd10: begin ma = f_reg.du1; mb = f_reg.e2y; end
            4'd11: begin ma = f_reg.du2; mb = f_reg.e1y; end
            4'd12: begin ma = f_reg.du1; mb = f_reg.e2z; end
            4'd13: begin ma = f_reg.du2; mb = f_reg.e1z; end
            default: begin ma = '0; mb = '0; end
        endcase
    end
    logic signed [65:0] prod;
    assign prod = ma * mb;

    // Components of the current vector; their sign is later folded with det sign.
    logic signed [67:0] vs [3];
    always_comb begin
        for (int i = 0; i < 3; i++) vs[i] = v_reg[{vec_reg, 2'b00} == 3'd0 ? i : i + 3];
    end

    // Bit length of the largest magnitude (or of the OR, same length).
    logic [67:0] orm;
    logic [6:0]  blen;
    assign orm = mag_reg[0] | mag_reg[1] | mag_reg[2];
    always_comb begin
        blen = '0;
        for (int i = 0; i < 68; i++) if (orm[i]) blen = 7'(i + 1);
    end

    function automatic logic [23:0] scl(input logic [67:0] m, input logic [6:0] b);
        logic [67:0] t;
        t = (b > 7'd24) ? (m >> (b - 7'd24)) : (m << (7'd24 - b));
        scl = t[23:0];
    endfunction

    // Scaled components and their sum of squares.
    logic [23:0] cs [3];
    logic [47:0] sq [3];
    logic [49:0] ssq;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cs[i] = scl(mag_reg[i], blen);
            sq[i] = cs[i] * cs[i];
        end
        ssq = {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};
    end

    // Sqrt step (two bits per cycle): restoring
    logic [49:0] trial;
    assign trial = {rem_reg[47:0], s_reg[49:48]} - {23'd0, root_reg, 2'b01};

    assign face_ready = (state_reg == S_IDLE);
    assign res_valid  = rv_reg;
    assign res.tx = res_out_reg[0]; assign res.ty = res_out_reg[1];
    assign res.tz = res_out_reg[2];
    assign res.bx = res_out_reg[3]; assign res.by = res_out_reg[4];
    assign res.bz = res_out_reg[5];
    assign res.degenerate = res_deg_reg;

    // Division by a 25-bit root: long division, one bit a cycle.
    logic [25:0] drem_sh;
    logic [24:0] drem_reg;
    assign drem_sh = {drem_reg, num_reg[39]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
        end else begin
            if (state_reg == S_OUT && (!rv_reg || res_ready)) rv_reg <= 1'b1;
            else if (res_ready) rv_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (face_valid) begin
                    f_reg     <= face;
                    step_reg  <= '0;
                    vec_reg   <= 1'b0;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    prod_reg[step_reg] <= prod;
                    if (step_reg == 4'd13) state_reg <= S_SUM;
                    else step_reg <= step_reg + 4'd1;
                end
                S_SUM: begin
                    det_reg <= 68'(prod_reg[0]) - 68'(prod_reg[1]);
                    for (int i = 0; i < 6; i++)
                        v_reg[i] <= 68'(prod_reg[2+2*i]) - 68'(prod_reg[3+2*i]);
                    state_reg <= S_MAG;
                    vec_reg   <= 1'b0;
                    bad_reg   <= 1'b0;
                end
                S_MAG: begin
                    flip_reg <= det_reg[67];
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i] <= vs[i][67] ? 68'(-vs[i]) : 68'(vs[i]);
                        neg_reg[i] <= vs[i][67] ^ det_reg[67];
                    end
                    state_reg <= S_SQ;
                end
                S_SQ: begin
                    if (det_reg == '0 || orm == '0) begin
                        bad_reg   <= 1'b1;
                        for (int i = 0; i < 6; i++) out_reg[i] <= '0;
                        state_reg <= S_OUT;
                    end else begin
                        for (int i = 0; i < 3; i++) c_reg[i] <= cs[i];
                        s_reg     <= ssq;
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        it_reg    <= '0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (!trial[49]) begin
                        rem_reg  <= trial;
                        root_reg <= {root_reg[23:0], 1'b1};
                    end else begin
                        rem_reg  <= {rem_reg[47:0], s_reg[49:48]};
                        root_reg <= {root_reg[23:0], 1'b0};
                    end
                    s_reg  <= {s_reg[47:0], 2'b00};
                    it_reg <= it_reg + 6'd1;
                    if (it_reg == 6'd24) begin
                        comp_reg  <= 2'd0;
                        it_reg    <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (it_reg == 6'd0) begin
                        num_reg  <= {2'b00, c_reg[comp_reg], 14'd0} + 40'(root_reg[24:1]);
                        drem_reg <= '0;
                        q_reg    <= '0;
                        it_reg   <= 6'd1;
                    end else if (it_reg <= 6'd40) begin
                        if (drem_sh >= {1'b0, root_reg}) begin
                            drem_reg <= 25'(drem_sh - {1'b0, root_reg});
                            q_reg    <= {q_reg[23:0], 1'b1};
                        end else begin
                            drem_reg <= drem_sh[24:0];
                            q_reg    <= {q_reg[23:0], 1'b0};
                        end
                        num_reg <= {num_reg[38:0], 1'b0};
                        it_reg  <= it_reg + 6'd1;
                    end else begin
                        out_reg[{1'b0, comp_reg} + (vec_reg ? 3'd3 : 3'd0)] <=
                            neg_reg[comp_reg] ? -16'(q_reg) : 16'(q_reg);
                        it_reg <= '0;
                        if (comp_reg == 2'd2) begin
                            if (vec_reg) state_reg <= S_OUT;
                            else begin vec_reg <= 1'b1; state_reg <= S_MAG; end
                        end else comp_reg <= comp_reg + 2'd1;
                    end
                end
                S_OUT: if (!rv_reg || res_ready) begin
                    for (int i = 0; i < 6; i++)
                        res_out_reg[i] <= bad_reg ? 16'sd0 : out_reg[i];
                    res_deg_reg <= bad_reg;
                    state_reg   <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/triangle_tangent_binormal_unit.sv =====
// ---------------------------------------------------------------------------
// triangle_tangent_binormal_unit
// Per-face tangent and binormal unit vectors from a vertex stream.
// ---------------------------------------------------------------------------
// channel | dir | tdata fields (low first)                       | tuser
// s_      | in  | pos_x pos_y pos_z tex_u tex_v (160b)           | restart
// m_      | out | tangent_x..z binormal_x..z (96b)               | degenerate
// A vertex is taken while s_tready is high; the front holds one finished
// face while the back works. The back's time per face is set mainly by the
// two 25-step square roots and the six 40-step bit-serial divides, which a
// face with a zero determinant skips. The result waits in its own output register,
// so the back only stalls when a new result is ready before the last left.
// Reset clears the corner count and all valid flags.
// ---------------------------------------------------------------------------
module triangle_tangent_binormal_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
    input  logic         s_tuser,   // restart
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // tangent_x/y/z, binormal_x/y/z
    output logic         m_tuser    // degenerate
);
    logic fv, fr;
    ttb_pkg::face_t face;
    ttb_pkg::result_t res;

    ttb_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .px(s_tdata[31:0]), .py(s_tdata[63:32]), .pz(s_tdata[95:64]),
        .tu(s_tdata[127:96]), .tv(s_tdata[159:128]), .restart(s_tuser),
        .face_valid(fv), .face_ready(fr), .face(face)
    );

    ttb_back u_back (
        .aclk(aclk), .aresetn(aresetn), .face_valid(fv), .face_ready(fr),
        .face(face), .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
    );

    assign m_tdata = {res.bz, res.by, res.bx, res.tz, res.ty, res.tx};
    assign m_tuser = res.degenerate;
endmodule

// ===== rtl/ttb_checker.sv =====
// ---------------------------------------------------------------------------
// ttb_checker
// Port-level checks for the tangent/binormal unit.
// ---------------------------------------------------------------------------
module ttb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("degenerate result carries nonzero vector");
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("valid after reset");
endmodule

bind triangle_tangent_binormal_unit ttb_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
